>>> rtl/assert_macros.svh
// Assertion macros shared by the SNI extractor modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every edge outside reset
`define TLSSNI_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Antecedent at one edge implies consequent at the next edge
`define TLSSNI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tlssni_pkg.sv
// Types and constants of the TLS ClientHello SNI extractor
package tlssni_pkg;

    typedef enum logic [4:0] {
        PH_REC_TYPE,
        PH_REC_SKIP,
        PH_HS_TYPE,
        PH_HS_SKIP,
        PH_SID_LEN,
        PH_SID_SKIP,
        PH_CS_HI,
        PH_CS_LO,
        PH_CS_SKIP,
        PH_CM_LEN,
        PH_CM_SKIP,
        PH_EL_HI,
        PH_EL_LO,
        PH_ET_HI,
        PH_ET_LO,
        PH_EX_HI,
        PH_EX_LO,
        PH_EX_SKIP,
        PH_SL_HI,
        PH_SL_LO,
        PH_SN_TYPE,
        PH_NL_HI,
        PH_NL_LO,
        PH_NAME,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        V_FOUND   = 3'd0,
        V_SHORT   = 3'd1,
        V_NOT_HS  = 3'd2,
        V_NOT_CH  = 3'd3,
        V_OVERRUN = 3'd4,
        V_NO_SNI  = 3'd5
    } t_verdict;

    localparam logic KIND_NAME    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [7:0]  REC_HANDSHAKE   = 8'h16;
    localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
    localparam logic [7:0]  SNI_HOST_NAME   = 8'h00;
    localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;
    localparam logic [15:0] MIN_LENGTH      = 16'd43;
    localparam logic [7:0]  REC_HDR_LAST    = 8'd4;
    localparam logic [7:0]  RANDOM_LAST     = 8'd42;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [15:0] payload_length;
        logic        last_byte;
    } t_in_word;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] name_byte;
        logic       name_end;
        logic [2:0] verdict;
    } t_out_word;

    typedef struct packed {
        logic [1:0] count;
        t_out_word  first;
        t_out_word  second;
    } t_push;

endpackage

>>> rtl/tlssni_parser.sv
// ClientHello walk: parse state, field checks and result generation per byte
`include "assert_macros.svh"

module tlssni_parser #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  tlssni_pkg::t_in_word i_word,
    output tlssni_pkg::t_push    o_push
);

    localparam int SW = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 2;

    tlssni_pkg::t_phase   r_phase, n_phase;
    logic [LENGTH_BITS-1:0] r_pos, n_pos;
    logic [15:0]          r_skip, n_skip;
    logic [7:0]           r_acc, n_acc;
    logic [16:0]          r_exts_end, n_exts_end;
    logic [15:0]          r_ext_type, n_ext_type;
    logic [16:0]          r_ext_end, n_ext_end;
    logic [15:0]          r_name_rem, n_name_rem;
    tlssni_pkg::t_verdict r_verdict, n_verdict;

    logic [SW-1:0] w_nxt;
    logic [SW-1:0] w_b;
    logic [SW-1:0] w_len;
    logic [SW-1:0] w_v;
    logic [15:0]   w_v16;
    logic          w_walk;
    logic [SW-1:0] w_walk_p;
    logic [15:0]   w_walk_n;
    logic          w_name;
    tlssni_pkg::t_out_word w_name_word;
    tlssni_pkg::t_out_word w_verdict_word;

    assign w_nxt = SW'(r_pos) + SW'(1);
    assign w_b   = SW'(i_word.payload_byte);
    assign w_len = SW'(i_word.payload_length);
    assign w_v16 = {r_acc, i_word.payload_byte};
    assign w_v   = SW'(w_v16);

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_skip     = r_skip;
        n_acc      = r_acc;
        n_exts_end = r_exts_end;
        n_ext_type = r_ext_type;
        n_ext_end  = r_ext_end;
        n_name_rem = r_name_rem;
        n_verdict  = r_verdict;
        w_walk     = 1'b0;
        w_walk_p   = w_nxt;
        w_walk_n   = 16'd0;
        w_name     = 1'b0;
        w_name_word    = '0;
        w_verdict_word = '0;
        o_push     = '0;

        if (i_accept) begin
            case (r_phase)
                tlssni_pkg::PH_REC_TYPE: begin
                    if (i_word.payload_length < tlssni_pkg::MIN_LENGTH) begin
                        n_verdict = tlssni_pkg::V_SHORT;
                        n_phase   = tlssni_pkg::PH_DONE;
                    end else if (i_word.payload_byte != tlssni_pkg::REC_HANDSHAKE) begin
                        n_verdict = tlssni_pkg::V_NOT_HS;
                        n_phase   = tlssni_pkg::PH_DONE;
                    end else begin
                        n_phase = tlssni_pkg::PH_REC_SKIP;
                    end
                end
                tlssni_pkg::PH_REC_SKIP: begin
                    if (r_pos >= LENGTH_BITS'(tlssni_pkg::REC_HDR_LAST)) begin
                        n_phase = tlssni_pkg::PH_HS_TYPE;
                    end
                end
                tlssni_pkg::PH_HS_TYPE: begin
                    if (i_word.payload_byte != tlssni_pkg::HS_CLIENT_HELLO) begin
                        n_verdict = tlssni_pkg::V_NOT_CH;
                        n_phase   = tlssni_pkg::PH_DONE;
                    end else begin
                        n_phase = tlssni_pkg::PH_HS_SKIP;
                    end
                end
                tlssni_pkg::PH_HS_SKIP: begin
                    if (r_pos >= LENGTH_BITS'(tlssni_pkg::RANDOM_LAST)) begin
                        n_phase = tlssni_pkg::PH_SID_LEN;
                    end
                end
                tlssni_pkg::PH_SID_LEN: begin
                    if (w_nxt + w_b + SW'(2) > w_len) begin
                        n_verdict = tlssni_pkg::V_OVERRUN;
                        n_phase   = tlssni_pkg::PH_DONE;
                    end else begin
                        n_skip  = 16'(i_word.payload_byte);
                        n_phase = (i_word.payload_byte == 8'd0) ? tlssni_pkg::PH_CS_HI
                                                                : tlssni_pkg::PH_SID_SKIP;
                    end
                end
                tlssni_pkg::PH_SID_SKIP: begin
                    n_skip = r_skip - 16'd1;
                    if (r_skip == 16'd1) begin
                        n_phase = tlssni_pkg::PH_CS_HI;
                    end
                end
                tlssni_pkg::PH_CS_HI: begin
                    n_acc   = i_word.payload_byte;
                    n_phase = tlssni_pkg::PH_CS_LO;
                end
                tlssni_pkg::PH_CS_LO: begin
                    if (w_nxt + w_v + SW'(1) > w_len) begin
                        n_verdict = tlssni_pkg::V_OVERRUN;
                        n_phase   = tlssni_pkg::PH_DONE;
                    end else begin
                        n_skip  = w_v16;
                        n_phase = (w_v16 == 16'd0) ? tlssni_pkg::PH_CM_LEN
                                                   : tlssni_pkg::PH_CS_SKIP;
                    end
                end
                tlssni_pkg::PH_CS_SKIP: begin
                    n_skip = r_skip - 16'd1;
                    if (r_skip == 16'd1) begin
                        n_phase = tlssni_pkg::PH_CM_LEN;
                    end
                end
                tlssni_pkg::PH_CM_LEN: begin
                    if (w_nxt + w_b + SW'(2) > w_len) begin
                        n_verdict = tlssni_pkg::V_OVERRUN;
                        n_phase   = tlssni_pkg::PH_DONE;
                    end else begin
                        n_skip  = 16'(i_word.payload_byte);
                        n_phase = (i_word.payload_byte == 8'd0) ? tlssni_pkg::PH_EL_HI
                                                                : tlssni_pkg::PH_CM_SKIP;
                    end
                end
                tlssni_pkg::PH_CM_SKIP: begin
                    n_skip = r_skip - 16'd1;
                    if (r_skip == 16'd1) begin
                        n_phase = tlssni_pkg::PH_EL_HI;
                    end
                end
                tlssni_pkg::PH_EL_HI: begin
                    n_acc   = i_word.payload_byte;
                    n_phase = tlssni_pkg::PH_EL_LO;
                end
                tlssni_pkg::PH_EL_LO: begin
                    if (w_nxt + w_v > w_len) begin
                        n_verdict = tlssni_pkg::V_OVERRUN;
                        n_phase   = tlssni_pkg::PH_DONE;
                    end else begin
                        n_exts_end = 17'(w_nxt + w_v);
                        w_walk     = 1'b1;
                        w_walk_p   = w_nxt;
                        w_walk_n   = 16'd0;
                    end
                end
                tlssni_pkg::PH_ET_HI: begin
                    n_ext_type = {i_word.payload_byte, 8'd0};
                    n_phase    = tlssni_pkg::PH_ET_LO;
                end
                tlssni_pkg::PH_ET_LO: begin
                    n_ext_type = r_ext_type | 16'(i_word.payload_byte);
                    n_phase    = tlssni_pkg::PH_EX_HI;
                end
                tlssni_pkg::PH_EX_HI: begin
                    n_acc   = i_word.payload_byte;
                    n_phase = tlssni_pkg::PH_EX_LO;
                end
                tlssni_pkg::PH_EX_LO: begin
                    n_ext_end = 17'(w_nxt + w_v);
                    if (r_ext_type == tlssni_pkg::EXT_SERVER_NAME) begin
                        if (w_nxt + SW'(2) > SW'(r_exts_end)) begin
                            n_verdict = tlssni_pkg::V_OVERRUN;
                            n_phase   = tlssni_pkg::PH_DONE;
                        end else begin
                            n_phase = tlssni_pkg::PH_SL_HI;
                        end
                    end else begin
                        w_walk   = 1'b1;
                        w_walk_p = w_nxt + w_v;
                        w_walk_n = w_v16;
                    end
                end
                tlssni_pkg::PH_EX_SKIP: begin
                    n_skip = r_skip - 16'd1;
                    if (r_skip == 16'd1) begin
                        n_phase = tlssni_pkg::PH_ET_HI;
                    end
                end
                tlssni_pkg::PH_SL_HI: begin
                    n_phase = tlssni_pkg::PH_SL_LO;
                end
                tlssni_pkg::PH_SL_LO: begin
                    if (w_nxt + SW'(3) > SW'(r_exts_end)) begin
                        n_verdict = tlssni_pkg::V_OVERRUN;
                        n_phase   = tlssni_pkg::PH_DONE;
                    end else begin
                        n_phase = tlssni_pkg::PH_SN_TYPE;
                    end
                end
                tlssni_pkg::PH_SN_TYPE: begin
                    if (i_word.payload_byte == tlssni_pkg::SNI_HOST_NAME) begin
                        n_phase = tlssni_pkg::PH_NL_HI;
                    end else if (SW'(r_ext_end) > w_nxt) begin
                        w_walk   = 1'b1;
                        w_walk_p = SW'(r_ext_end);
                        w_walk_n = 16'(SW'(r_ext_end) - w_nxt);
                    end else begin
                        w_walk   = 1'b1;
                        w_walk_p = w_nxt;
                        w_walk_n = 16'd0;
                    end
                end
                tlssni_pkg::PH_NL_HI: begin
                    n_acc   = i_word.payload_byte;
                    n_phase = tlssni_pkg::PH_NL_LO;
                end
                tlssni_pkg::PH_NL_LO: begin
                    if (w_v16 == 16'd0 || w_nxt + w_v > SW'(r_exts_end)) begin
                        n_verdict = tlssni_pkg::V_NO_SNI;
                        n_phase   = tlssni_pkg::PH_DONE;
                    end else begin
                        n_name_rem = w_v16;
                        n_phase    = tlssni_pkg::PH_NAME;
                    end
                end
                tlssni_pkg::PH_NAME: begin
                    w_name                  = 1'b1;
                    w_name_word.result_kind = tlssni_pkg::KIND_NAME;
                    w_name_word.name_byte   = i_word.payload_byte;
                    w_name_word.name_end    = (r_name_rem == 16'd1);
                    n_name_rem              = r_name_rem - 16'd1;
                    if (r_name_rem == 16'd1) begin
                        n_verdict = tlssni_pkg::V_FOUND;
                        n_phase   = tlssni_pkg::PH_DONE;
                    end
                end
                default: begin
                    n_phase = tlssni_pkg::PH_DONE;
                end
            endcase

            if (w_walk) begin
                if (w_walk_p + SW'(4) > SW'(n_exts_end)) begin
                    n_verdict = tlssni_pkg::V_NO_SNI;
                    n_phase   = tlssni_pkg::PH_DONE;
                end else begin
                    n_skip  = w_walk_n;
                    n_phase = (w_walk_n == 16'd0) ? tlssni_pkg::PH_ET_HI
                                                  : tlssni_pkg::PH_EX_SKIP;
                end
            end

            n_pos = r_pos + LENGTH_BITS'(1);

            w_verdict_word.result_kind = tlssni_pkg::KIND_VERDICT;
            w_verdict_word.verdict     = (n_phase == tlssni_pkg::PH_DONE) ? n_verdict
                                                                          : tlssni_pkg::V_OVERRUN;

            if (w_name && i_word.last_byte) begin
                o_push.count  = 2'd2;
                o_push.first  = w_name_word;
                o_push.second = w_verdict_word;
            end else if (w_name) begin
                o_push.count = 2'd1;
                o_push.first = w_name_word;
            end else if (i_word.last_byte) begin
                o_push.count = 2'd1;
                o_push.first = w_verdict_word;
            end

            if (i_word.last_byte) begin
                n_phase    = tlssni_pkg::PH_REC_TYPE;
                n_pos      = '0;
                n_skip     = '0;
                n_acc      = '0;
                n_exts_end = '0;
                n_ext_type = '0;
                n_ext_end  = '0;
                n_name_rem = '0;
                n_verdict  = tlssni_pkg::V_NO_SNI;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= tlssni_pkg::PH_REC_TYPE;
            r_pos      <= '0;
            r_skip     <= '0;
            r_acc      <= '0;
            r_exts_end <= '0;
            r_ext_type <= '0;
            r_ext_end  <= '0;
            r_name_rem <= '0;
            r_verdict  <= tlssni_pkg::V_NO_SNI;
        end else begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_skip     <= n_skip;
            r_acc      <= n_acc;
            r_exts_end <= n_exts_end;
            r_ext_type <= n_ext_type;
            r_ext_end  <= n_ext_end;
            r_name_rem <= n_name_rem;
            r_verdict  <= n_verdict;
        end
    end

    `TLSSNI_ASSERT_NEXT(a_restart_after_last, i_accept && i_word.last_byte,
        r_phase == tlssni_pkg::PH_REC_TYPE && r_pos == '0, "parse not restarted after last byte")
    `TLSSNI_ASSERT_ALWAYS(a_two_words_only_on_name_end,
        o_push.count != 2'd2 || (i_word.last_byte && r_phase == tlssni_pkg::PH_NAME),
        "two words pushed outside a last name byte")
    `TLSSNI_ASSERT_ALWAYS(a_push_needs_accept, i_accept || o_push.count == 2'd0,
        "word pushed without an accepted byte")

endmodule

>>> rtl/tlssni_out_fifo.sv
// Result queue taking up to two words per cycle and giving one per cycle while not stalled
`include "assert_macros.svh"

module tlssni_out_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tlssni_pkg::t_push     i_push,
    output logic                  o_room,
    output logic                  o_valid,
    input  logic                  i_stall,
    output tlssni_pkg::t_out_word o_word
);

    localparam int DEPTH = tlssni_pkg::FIFO_DEPTH;
    localparam int PW    = tlssni_pkg::FIFO_PTR_W;
    localparam int CW    = tlssni_pkg::FIFO_CNT_W;

    tlssni_pkg::t_out_word r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          w_pop;

    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= CW'(DEPTH - 2));
    assign o_word  = r_mem[r_rd_ptr];
    assign w_pop   = o_valid && !i_stall;

    always_comb begin
        n_wr_ptr = r_wr_ptr + PW'(i_push.count);
        n_rd_ptr = r_rd_ptr + PW'(w_pop);
        n_count  = r_count + CW'(i_push.count) - CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr_ptr + PW'(1)] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `TLSSNI_ASSERT_ALWAYS(a_count_bounded, r_count <= CW'(DEPTH), "queue count above depth")
    `TLSSNI_ASSERT_NEXT(a_count_tracks, 1'b1,
        r_count == $past(r_count) + CW'($past(i_push.count)) - CW'($past(w_pop)),
        "queue count out of step with push and pop")
    `TLSSNI_ASSERT_ALWAYS(a_push_with_room, i_push.count == 2'd0 || o_room,
        "word pushed into a full queue")

endmodule

>>> rtl/tls_client_hello_sni_extractor_unit.sv
// TLS ClientHello SNI extractor: top level
//
// Input channel: one TCP payload byte per word, with the payload's total
// length held on every byte and a mark on its last byte. A word is taken at
// a rising edge with i_in_valid high and o_in_stall low.
// Output channel: one result per word, either a host name byte (with a mark
// on the final name byte) or, for the payload's last byte, a verdict code.
// A word leaves at an edge with o_out_valid high and i_out_stall low.
// Each byte is parsed in the cycle it is taken; its results are registered
// in the queue and shown from there. One byte is taken every cycle while
// the queue has room for two words; a last byte that is also a name byte
// gives two words, so the output side sets the sustained rate at one word a
// cycle. When the receiver stalls, the queue fills and o_in_stall rises once
// fewer than two places are free; nothing is lost.
// Reset clears the parse and empties the queue; the first byte after it
// starts a new payload.

module tls_client_hello_sni_extractor_unit #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  tlssni_pkg::t_in_word  i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output tlssni_pkg::t_out_word o_out_word
);

    logic              w_accept;
    logic              w_room;
    tlssni_pkg::t_push w_push;

    assign o_in_stall = !w_room;
    assign w_accept   = i_in_valid && w_room;

    tlssni_parser #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_word   (i_in_word),
        .o_push   (w_push)
    );

    tlssni_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_word  (o_out_word)
    );

endmodule

>>> test/tb_tls_client_hello_sni_extractor_unit.sv
// Self-checking testbench of the TLS ClientHello SNI extractor with a built-in parse predictor
`timescale 1ns / 100ps

module tb_tls_client_hello_sni_extractor_unit;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 700;

    typedef struct {
        int         sid_len;
        int         suite_len;
        int         comp_len;
        int         exts_before;
        int         exts_after;
        bit         has_sni;
        logic [7:0] entry_kind;
        int         name_len;
        int         name_excess;
        bit         sni_len_bad;
        int         list_short;
    } t_hello_shape;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    tlssni_pkg::t_in_word  i_in_word = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    tlssni_pkg::t_out_word o_out_word;

    tlssni_pkg::t_out_word sni_words_due[$];
    logic [7:0]            frame_q[$];

    tlssni_pkg::t_phase   ph;
    logic [15:0]          pos_r;
    logic [15:0]          skip_r;
    logic [15:0]          acc_r;
    logic [15:0]          etype_r;
    logic [15:0]          name_left_r;
    logic [16:0]          list_end_r;
    logic [16:0]          ext_end_r;
    tlssni_pkg::t_verdict held_r;

    bit steady = 1'b0;
    int cycle_count = 0;
    int mismatches = 0;
    int words_sent = 0;
    int payloads_sent = 0;
    int names_seen = 0;
    int verdicts_seen = 0;

    tls_client_hello_sni_extractor_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still due", cycle_count,
                     sni_words_due.size());
            $display("tb_tls_client_hello_sni_extractor_unit NOT OK");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(99) < 23);
    end

    task automatic flag_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    task automatic expect_word(input tlssni_pkg::t_out_word r);
        sni_words_due.insert(sni_words_due.size(), r);
    endtask

    task automatic add_byte(input logic [7:0] b);
        frame_q.insert(frame_q.size(), b);
    endtask

    // Parse predictor state handling
    function automatic void restart_parse();
        ph          = tlssni_pkg::PH_REC_TYPE;
        pos_r       = '0;
        skip_r      = '0;
        acc_r       = '0;
        etype_r     = '0;
        name_left_r = '0;
        list_end_r  = '0;
        ext_end_r   = '0;
        held_r      = tlssni_pkg::V_NO_SNI;
    endfunction

    function automatic void close_parse(input tlssni_pkg::t_verdict v);
        held_r = v;
        ph     = tlssni_pkg::PH_DONE;
    endfunction

    function automatic void skip_to(input int unsigned n, input tlssni_pkg::t_phase skip_ph,
                                    input tlssni_pkg::t_phase next_ph);
        skip_r = n[15:0];
        ph     = (skip_r == 16'd0) ? next_ph : skip_ph;
    endfunction

    function automatic void walk_on(input int unsigned p, input int unsigned n);
        if (p + 4 > list_end_r) close_parse(tlssni_pkg::V_NO_SNI);
        else skip_to(n, tlssni_pkg::PH_EX_SKIP, tlssni_pkg::PH_ET_HI);
    endfunction

    task automatic parse_sni_byte(input tlssni_pkg::t_in_word w);
        int unsigned           b;
        int unsigned           len;
        int unsigned           nxt;
        int unsigned           v;
        tlssni_pkg::t_out_word r;
        b   = w.payload_byte;
        len = w.payload_length;
        nxt = pos_r + 1;
        case (ph)
            tlssni_pkg::PH_REC_TYPE: begin
                if (len < tlssni_pkg::MIN_LENGTH) close_parse(tlssni_pkg::V_SHORT);
                else if (w.payload_byte != tlssni_pkg::REC_HANDSHAKE)
                    close_parse(tlssni_pkg::V_NOT_HS);
                else ph = tlssni_pkg::PH_REC_SKIP;
            end
            tlssni_pkg::PH_REC_SKIP: begin
                if (pos_r >= tlssni_pkg::REC_HDR_LAST) ph = tlssni_pkg::PH_HS_TYPE;
            end
            tlssni_pkg::PH_HS_TYPE: begin
                if (w.payload_byte != tlssni_pkg::HS_CLIENT_HELLO)
                    close_parse(tlssni_pkg::V_NOT_CH);
                else ph = tlssni_pkg::PH_HS_SKIP;
            end
            tlssni_pkg::PH_HS_SKIP: begin
                if (pos_r >= tlssni_pkg::RANDOM_LAST) ph = tlssni_pkg::PH_SID_LEN;
            end
            tlssni_pkg::PH_SID_LEN: begin
                if (nxt + b + 2 > len) close_parse(tlssni_pkg::V_OVERRUN);
                else skip_to(b, tlssni_pkg::PH_SID_SKIP, tlssni_pkg::PH_CS_HI);
            end
            tlssni_pkg::PH_SID_SKIP: begin
                skip_r = skip_r - 16'd1;
                if (skip_r == 16'd0) ph = tlssni_pkg::PH_CS_HI;
            end
            tlssni_pkg::PH_CS_HI: begin
                acc_r = 16'(b);
                ph    = tlssni_pkg::PH_CS_LO;
            end
            tlssni_pkg::PH_CS_LO: begin
                v = acc_r * 256 + b;
                if (nxt + v + 1 > len) close_parse(tlssni_pkg::V_OVERRUN);
                else skip_to(v, tlssni_pkg::PH_CS_SKIP, tlssni_pkg::PH_CM_LEN);
            end
            tlssni_pkg::PH_CS_SKIP: begin
                skip_r = skip_r - 16'd1;
                if (skip_r == 16'd0) ph = tlssni_pkg::PH_CM_LEN;
            end
            tlssni_pkg::PH_CM_LEN: begin
                if (nxt + b + 2 > len) close_parse(tlssni_pkg::V_OVERRUN);
                else skip_to(b, tlssni_pkg::PH_CM_SKIP, tlssni_pkg::PH_EL_HI);
            end
            tlssni_pkg::PH_CM_SKIP: begin
                skip_r = skip_r - 16'd1;
                if (skip_r == 16'd0) ph = tlssni_pkg::PH_EL_HI;
            end
            tlssni_pkg::PH_EL_HI: begin
                acc_r = 16'(b);
                ph    = tlssni_pkg::PH_EL_LO;
            end
            tlssni_pkg::PH_EL_LO: begin
                v = nxt + acc_r * 256 + b;
                if (v > len) begin
                    close_parse(tlssni_pkg::V_OVERRUN);
                end else begin
                    list_end_r = v[16:0];
                    walk_on(nxt, 0);
                end
            end
            tlssni_pkg::PH_ET_HI: begin
                etype_r = {w.payload_byte, 8'h00};
                ph      = tlssni_pkg::PH_ET_LO;
            end
            tlssni_pkg::PH_ET_LO: begin
                etype_r = etype_r | 16'(b);
                ph      = tlssni_pkg::PH_EX_HI;
            end
            tlssni_pkg::PH_EX_HI: begin
                acc_r = 16'(b);
                ph    = tlssni_pkg::PH_EX_LO;
            end
            tlssni_pkg::PH_EX_LO: begin
                v         = acc_r * 256 + b;
                ext_end_r = 17'(nxt + v);
                if (etype_r == tlssni_pkg::EXT_SERVER_NAME) begin
                    if (nxt + 2 > list_end_r) close_parse(tlssni_pkg::V_OVERRUN);
                    else ph = tlssni_pkg::PH_SL_HI;
                end else begin
                    walk_on(nxt + v, v);
                end
            end
            tlssni_pkg::PH_EX_SKIP: begin
                skip_r = skip_r - 16'd1;
                if (skip_r == 16'd0) ph = tlssni_pkg::PH_ET_HI;
            end
            tlssni_pkg::PH_SL_HI: ph = tlssni_pkg::PH_SL_LO;
            tlssni_pkg::PH_SL_LO: begin
                if (nxt + 3 > list_end_r) close_parse(tlssni_pkg::V_OVERRUN);
                else ph = tlssni_pkg::PH_SN_TYPE;
            end
            tlssni_pkg::PH_SN_TYPE: begin
                if (w.payload_byte == tlssni_pkg::SNI_HOST_NAME) ph = tlssni_pkg::PH_NL_HI;
                else if (ext_end_r > nxt) walk_on(ext_end_r, ext_end_r - nxt);
                else walk_on(nxt, 0);
            end
            tlssni_pkg::PH_NL_HI: begin
                acc_r = 16'(b);
                ph    = tlssni_pkg::PH_NL_LO;
            end
            tlssni_pkg::PH_NL_LO: begin
                v = acc_r * 256 + b;
                if (v == 0 || nxt + v > list_end_r) begin
                    close_parse(tlssni_pkg::V_NO_SNI);
                end else begin
                    name_left_r = v[15:0];
                    ph          = tlssni_pkg::PH_NAME;
                end
            end
            tlssni_pkg::PH_NAME: begin
                r.result_kind = tlssni_pkg::KIND_NAME;
                r.name_byte   = w.payload_byte;
                r.name_end    = (name_left_r == 16'd1);
                r.verdict     = '0;
                expect_word(r);
                name_left_r = name_left_r - 16'd1;
                if (name_left_r == 16'd0) close_parse(tlssni_pkg::V_FOUND);
            end
            default: ph = tlssni_pkg::PH_DONE;
        endcase
        pos_r = pos_r + 16'd1;
        if (w.last_byte) begin
            r.result_kind = tlssni_pkg::KIND_VERDICT;
            r.name_byte   = '0;
            r.name_end    = 1'b0;
            r.verdict     = (ph == tlssni_pkg::PH_DONE) ? held_r : tlssni_pkg::V_OVERRUN;
            expect_word(r);
            restart_parse();
        end
    endtask

    always @(posedge i_clk) begin : check_results
        tlssni_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (sni_words_due.size() == 0) begin
                flag_mismatch($sformatf("word %p with nothing due", o_out_word));
            end else begin
                want = sni_words_due.pop_front();
                if (o_out_word.result_kind !== want.result_kind)
                    flag_mismatch($sformatf("result_kind %0d, want %0d",
                                            o_out_word.result_kind, want.result_kind));
                if (o_out_word.name_byte !== want.name_byte)
                    flag_mismatch($sformatf("name_byte %02h, want %02h",
                                            o_out_word.name_byte, want.name_byte));
                if (o_out_word.name_end !== want.name_end)
                    flag_mismatch($sformatf("name_end %0d, want %0d",
                                            o_out_word.name_end, want.name_end));
                if (o_out_word.verdict !== want.verdict)
                    flag_mismatch($sformatf("verdict %0d, want %0d",
                                            o_out_word.verdict, want.verdict));
                if (want.result_kind == tlssni_pkg::KIND_VERDICT) verdicts_seen++;
                else names_seen++;
            end
        end
    end

    // Enter at a falling edge, leave at the falling edge after the word is taken
    task automatic send_byte(input logic [7:0] data, input logic [15:0] len,
                             input logic last);
        tlssni_pkg::t_in_word w;
        bit                   taken;
        w.payload_byte   = data;
        w.payload_length = len;
        w.last_byte      = last;
        while (!steady && $urandom_range(99) < 23) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !o_in_stall;
        end
        parse_sni_byte(w);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_payload(input logic [15:0] len);
        for (int i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], len, i == frame_q.size() - 1);
        payloads_sent++;
    endtask

    task automatic push_random(input int n);
        repeat (n) add_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic push_word(input int v);
        add_byte(v[15:8]);
        add_byte(v[7:0]);
    endtask

    function automatic t_hello_shape plain_shape();
        t_hello_shape s;
        s.sid_len     = 0;
        s.suite_len   = 2;
        s.comp_len    = 1;
        s.exts_before = 0;
        s.exts_after  = 0;
        s.has_sni     = 1'b1;
        s.entry_kind  = tlssni_pkg::SNI_HOST_NAME;
        s.name_len    = 4;
        s.name_excess = 0;
        s.sni_len_bad = 1'b0;
        s.list_short  = 0;
        return s;
    endfunction

    function automatic t_hello_shape random_shape();
        t_hello_shape s;
        s.sid_len     = ($urandom_range(99) < 5) ? 32 : $urandom_range(0, 4);
        s.suite_len   = $urandom_range(0, 6);
        s.comp_len    = $urandom_range(0, 2);
        s.exts_before = $urandom_range(0, 2);
        s.exts_after  = $urandom_range(0, 2);
        s.has_sni     = $urandom_range(99) < 90;
        s.entry_kind  = ($urandom_range(99) < 85) ? tlssni_pkg::SNI_HOST_NAME
                                                  : 8'($urandom_range(1, 255));
        s.name_len    = $urandom_range(1, 8);
        s.name_excess = ($urandom_range(99) < 10) ? $urandom_range(1, 4) : 0;
        s.sni_len_bad = $urandom_range(99) < 8;
        s.list_short  = ($urandom_range(99) < 8) ? $urandom_range(1, 12) : 0;
        return s;
    endfunction

    task automatic build_hello(input t_hello_shape s);
        int other_len[8];
        int total;
        frame_q.delete();
        add_byte(tlssni_pkg::REC_HANDSHAKE);
        push_random(4);
        add_byte(tlssni_pkg::HS_CLIENT_HELLO);
        push_random(37);
        add_byte(8'(s.sid_len));
        push_random(s.sid_len);
        push_word(s.suite_len);
        push_random(s.suite_len);
        add_byte(8'(s.comp_len));
        push_random(s.comp_len);
        total = s.has_sni ? 9 + s.name_len : 0;
        for (int i = 0; i < s.exts_before + s.exts_after; i++) begin
            other_len[i] = $urandom_range(0, 4);
            total += 4 + other_len[i];
        end
        push_word(total > s.list_short ? total - s.list_short : 0);
        for (int i = 0; i < s.exts_before + s.exts_after; i++) begin
            if (i == s.exts_before && s.has_sni) begin
                push_word(tlssni_pkg::EXT_SERVER_NAME);
                push_word(s.sni_len_bad ? $urandom_range(0, 3) : 5 + s.name_len);
                push_word(3 + s.name_len);
                add_byte(s.entry_kind);
                push_word(s.name_len + s.name_excess);
                push_random(s.name_len);
            end
            push_word($urandom_range(1, 65535));
            push_word(other_len[i]);
            push_random(other_len[i]);
        end
        if (s.has_sni && s.exts_after == 0) begin
            push_word(tlssni_pkg::EXT_SERVER_NAME);
            push_word(s.sni_len_bad ? $urandom_range(0, 3) : 5 + s.name_len);
            push_word(3 + s.name_len);
            add_byte(s.entry_kind);
            push_word(s.name_len + s.name_excess);
            push_random(s.name_len);
        end
    endtask

    task automatic test_short_payload();
        frame_q = '{tlssni_pkg::REC_HANDSHAKE};
        send_payload(16'd42);
        frame_q = '{8'hFF};
        send_payload(16'd0);
    endtask

    task automatic test_wrong_record();
        frame_q = '{8'h00, 8'hAA, 8'h55};
        send_payload(tlssni_pkg::MIN_LENGTH);
    endtask

    task automatic test_wrong_handshake();
        build_hello(plain_shape());
        frame_q[5] = 8'h02;
        while (frame_q.size() > 8) void'(frame_q.pop_back());
        send_payload(16'd200);
    endtask

    task automatic test_name_found();
        t_hello_shape s;
        s = plain_shape();
        s.name_len = 1;
        build_hello(s);
        send_payload(16'(frame_q.size()));
        s = plain_shape();
        s.sid_len     = 32;
        s.name_len    = 6;
        s.exts_before = 1;
        s.exts_after  = 1;
        build_hello(s);
        send_payload(16'hFFFF);
    endtask

    task automatic test_entry_kinds();
        t_hello_shape s;
        s = plain_shape();
        s.entry_kind = 8'hFF;
        s.exts_after = 1;
        build_hello(s);
        send_payload(16'(frame_q.size()));
        s = plain_shape();
        s.name_len = 0;
        build_hello(s);
        send_payload(16'(frame_q.size()));
        s = plain_shape();
        s.name_excess = 3;
        build_hello(s);
        send_payload(16'(frame_q.size()));
        s = plain_shape();
        s.sni_len_bad = 1'b1;
        s.entry_kind  = 8'h01;
        s.exts_after  = 1;
        build_hello(s);
        send_payload(16'(frame_q.size()));
        s = plain_shape();
        s.has_sni     = 1'b0;
        s.exts_before = 2;
        build_hello(s);
        send_payload(16'(frame_q.size()));
    endtask

    task automatic test_overruns();
        t_hello_shape s;
        build_hello(plain_shape());
        send_payload(16'd44);
        build_hello(plain_shape());
        send_payload(16'(frame_q.size() - 3));
        s = plain_shape();
        s.list_short = 9;
        build_hello(s);
        send_payload(16'(frame_q.size()));
        s.list_short = 6;
        build_hello(s);
        send_payload(16'(frame_q.size()));
    endtask

    task automatic test_early_last();
        t_hello_shape s;
        int           full;
        s = plain_shape();
        s.name_len = 6;
        build_hello(s);
        full = frame_q.size();
        repeat (3) void'(frame_q.pop_back());
        send_payload(16'(full));
    endtask

    task automatic test_random_traffic();
        int          first_word;
        int          n;
        int          kind;
        int          full;
        logic [15:0] declared;
        first_word = words_sent;
        n = 0;
        while (words_sent - first_word < RANDOM_WORDS) begin
            steady = (n >= 3 && n < 7);
            kind = $urandom_range(99);
            if (kind < 20) begin
                frame_q.delete();
                push_random($urandom_range(1, 40));
                if ($urandom_range(1)) frame_q[0] = tlssni_pkg::REC_HANDSHAKE;
                if (frame_q.size() > 5 && $urandom_range(1))
                    frame_q[5] = tlssni_pkg::HS_CLIENT_HELLO;
                declared = 16'($urandom_range(0, 65535));
            end else begin
                build_hello(random_shape());
                full = frame_q.size();
                declared = 16'(full);
                if (kind >= 80)
                    frame_q[$urandom_range(0, full - 1)] = 8'($urandom_range(0, 255));
                kind = $urandom_range(99);
                if (kind < 15) declared = 16'(full - $urandom_range(1, 20));
                else if (kind < 25) declared = 16'($urandom_range(full, 65535));
                if ($urandom_range(99) < 12)
                    repeat ($urandom_range(1, full - 1)) void'(frame_q.pop_back());
            end
            send_payload(declared);
            n++;
        end
        steady = 1'b0;
    endtask

    initial begin
        restart_parse();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_short_payload();
        test_wrong_record();
        test_wrong_handshake();
        test_name_found();
        test_entry_kinds();
        test_overruns();
        test_early_last();
        test_random_traffic();
        i_in_valid <= 1'b0;
        while (sni_words_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("%0d payloads in %0d words; checked %0d host name bytes and %0d verdicts",
                 payloads_sent, words_sent, names_seen, verdicts_seen);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0) begin
            $display("tb_tls_client_hello_sni_extractor_unit OK");
        end else begin
            $display("tb_tls_client_hello_sni_extractor_unit NOT OK");
        end
        $finish;
    end

endmodule
